// ===== hw/rtl/obbt_pkg.sv =====
// ============================================================================
// obbt_pkg: shared definitions for the oriented box overlap test
// Holds quaternion integer bits, command codes, queue depth and status bundle.
// ============================================================================
package obbt_pkg;

    // Integer bits of a quaternion component; the rest are fraction bits.
    localparam int QUAT_INT_BITS = 2;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/obbt_rot.sv =====
// ============================================================================
// obbt_rot: quaternion to rotation matrix
// Two stages: the nine component products, then the saturated matrix entries.
// ============================================================================
module obbt_rot #(
    parameter int IW = 16,
    parameter int QW = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [IW-1:0] q [4],
    output logic signed [QW-1:0] m [3][3]
);

    localparam int F  = QW - obbt_pkg::QUAT_INT_BITS;
    localparam int PW = 2 * IW;
    localparam int MW = 2 * IW + 4;

    localparam logic signed [MW-1:0] ONE2 = MW'(1) <<< (2 * F);
    localparam logic signed [MW-1:0] ONE  = MW'(1) <<< F;

    // Products: xx, yy, zz, xy, xz, yz, wx, wy, wz.
    logic signed [PW-1:0] p_reg [9];
    logic signed [MW-1:0] e     [3][3];
    logic signed [QW-1:0] m_reg [3][3];

    function automatic logic signed [QW-1:0] sat_entry(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] s;
        s = v >>> F;
        if (s > ONE)
        begin
            s = ONE;
        end
        else if (s < -ONE)
        begin
            s = -ONE;
        end
        return s[QW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(q[0] * q[0]);
            p_reg[1] <= PW'(q[1] * q[1]);
            p_reg[2] <= PW'(q[2] * q[2]);
            p_reg[3] <= PW'(q[0] * q[1]);
            p_reg[4] <= PW'(q[0] * q[2]);
            p_reg[5] <= PW'(q[1] * q[2]);
            p_reg[6] <= PW'(q[3] * q[0]);
            p_reg[7] <= PW'(q[3] * q[1]);
            p_reg[8] <= PW'(q[3] * q[2]);
        end
    end

    always_comb
    begin
        e[0][0] = ONE2 - ((MW'(p_reg[1]) + MW'(p_reg[2])) <<< 1);
        e[0][1] = (MW'(p_reg[3]) - MW'(p_reg[8])) <<< 1;
        e[0][2] = (MW'(p_reg[4]) + MW'(p_reg[7])) <<< 1;
        e[1][0] = (MW'(p_reg[3]) + MW'(p_reg[8])) <<< 1;
        e[1][1] = ONE2 - ((MW'(p_reg[0]) + MW'(p_reg[2])) <<< 1);
        e[1][2] = (MW'(p_reg[5]) - MW'(p_reg[6])) <<< 1;
        e[2][0] = (MW'(p_reg[4]) - MW'(p_reg[7])) <<< 1;
        e[2][1] = (MW'(p_reg[5]) + MW'(p_reg[6])) <<< 1;
        e[2][2] = ONE2 - ((MW'(p_reg[0]) + MW'(p_reg[1])) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m_reg[i][j] <= sat_entry(e[i][j]);
                end
            end
        end
    end

    assign m = m_reg;

endmodule

// ===== hw/rtl/obbt_front.sv =====
// ============================================================================
// obbt_front: input classification and reference box store
// Load beats replace the reference box; test beats enter a short queue
// together with the reference they are tested against.
// ============================================================================
module obbt_front #(
    parameter int CW = 32,
    parameter int QW = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  obbt_pkg::cmd_t                cmd,
    input  logic signed [CW-1:0]          center [3],
    input  logic        [CW-2:0]          extent [3],
    input  logic signed [QW-1:0]          quat   [4],
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [3*(CW+1)+6*(CW-1)+8*QW-1:0] q_data,
    output obbt_pkg::queue_status_t       status
);

    localparam int EW = 3 * (CW + 1) + 6 * (CW - 1) + 8 * QW;
    localparam int DEPTH = obbt_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH);
    localparam int F = QW - obbt_pkg::QUAT_INT_BITS;

    logic signed [CW-1:0] ref_center_reg [3];
    logic        [CW-2:0] ref_extent_reg [3];
    logic signed [QW-1:0] ref_quat_reg   [4];

    logic [EW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;

    logic          accept;
    logic          push;
    logic          pop;
    logic [EW-1:0] entry;
    logic signed [CW:0] d [3];

    assign in_ready = (count_reg != (AW + 1)'(DEPTH));
    assign accept   = in_valid && in_ready;
    assign push     = accept && (cmd == obbt_pkg::CMD_TEST);
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d[k] = (CW + 1)'(center[k]) - (CW + 1)'(ref_center_reg[k]);
        end
        entry = {quat[3], quat[2], quat[1], quat[0],
                 ref_quat_reg[3], ref_quat_reg[2], ref_quat_reg[1], ref_quat_reg[0],
                 extent[2], extent[1], extent[0],
                 ref_extent_reg[2], ref_extent_reg[1], ref_extent_reg[0],
                 d[2], d[1], d[0]};
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ref_center_reg[k] <= '0;
                ref_extent_reg[k] <= '0;
            end
            ref_quat_reg[0] <= '0;
            ref_quat_reg[1] <= '0;
            ref_quat_reg[2] <= '0;
            ref_quat_reg[3] <= QW'(1) << F;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (accept && (cmd == obbt_pkg::CMD_LOAD))
            begin
                ref_center_reg <= center;
                ref_extent_reg <= extent;
                ref_quat_reg   <= quat;
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    assign q_data       = mem[rd_ptr_reg];
    assign status.full  = !in_ready;
    assign status.empty = !q_valid;

endmodule

// ===== hw/rtl/obbt_back.sv =====
// ============================================================================
// obbt_back: separating axis pipeline
// Seven stages from a queued test beat to the registered overlap bit.
// ============================================================================
module obbt_back #(
    parameter int CW = 32,
    parameter int QW = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    output logic                                  q_ready,
    input  logic [3*(CW+1)+6*(CW-1)+8*QW-1:0]     q_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  overlap
);

    localparam int F  = QW - obbt_pkg::QUAT_INT_BITS;
    localparam int DW = CW + 1;
    localparam int XW = CW - 1;
    localparam int RW = QW + 4;
    localparam int TW = CW + 5;
    localparam int SW = CW + 10;
    localparam int OFS_A  = 3 * DW;
    localparam int OFS_B  = OFS_A + 3 * XW;
    localparam int OFS_QA = OFS_B + 3 * XW;
    localparam int OFS_QB = OFS_QA + 4 * QW;

    logic adv;
    logic [7:1] v_reg;

    logic signed [DW-1:0] d0 [3];
    logic signed [CW-1:0] a0 [3];
    logic signed [CW-1:0] b0 [3];
    logic signed [QW-1:0] qa0 [4];
    logic signed [QW-1:0] qb0 [4];

    logic signed [2*QW-1:0] pq_reg [4][4];
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [CW-1:0] a1_reg [3];
    logic signed [CW-1:0] a2_reg [3];
    logic signed [CW-1:0] a3_reg [3];
    logic signed [CW-1:0] a4_reg [3];
    logic signed [CW-1:0] a5_reg [3];
    logic signed [CW-1:0] b1_reg [3];
    logic signed [CW-1:0] b2_reg [3];
    logic signed [CW-1:0] b3_reg [3];
    logic signed [CW-1:0] b4_reg [3];
    logic signed [CW-1:0] b5_reg [3];
    logic signed [2*QW+1:0] rq_sum [4];
    logic signed [RW-1:0] rq_reg [4];
    logic signed [QW-1:0] ra [3][3];
    logic signed [QW-1:0] rm [3][3];
    logic signed [QW-1:0] em [3][3];
    logic signed [DW+QW-1:0] pd_reg [3][3];
    logic signed [TW-1:0] t4_reg [3];
    logic signed [TW-1:0] t5_reg [3];
    logic signed [TW+QW-1:0] pt_reg [3][3][3];
    logic signed [CW+QW-1:0] pa_reg [3][3][3];
    logic signed [CW+QW-1:0] pb_reg [3][3][3];
    logic signed [SW-1:0] p_next [15];
    logic signed [SW-1:0] r_next [15];
    logic signed [SW-1:0] p6_reg [15];
    logic signed [SW-1:0] r6_reg [15];
    logic                 sep;
    logic                 overlap_reg;

    assign adv       = !v_reg[7] || out_ready;
    assign q_ready   = adv;
    assign out_valid = v_reg[7];
    assign overlap   = overlap_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d0[k] = q_data[k*DW +: DW];
            a0[k] = {1'b0, q_data[OFS_A + k*XW +: XW]};
            b0[k] = {1'b0, q_data[OFS_B + k*XW +: XW]};
        end
        for (int k = 0; k < 4; k++)
        begin
            qa0[k] = q_data[OFS_QA + k*QW +: QW];
            qb0[k] = q_data[OFS_QB + k*QW +: QW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[6:1], q_valid};
        end
    end

    obbt_rot #(.IW(QW), .QW(QW)) u_rot_ref (
        .clk (clk),
        .en  (adv),
        .q   (qa0),
        .m   (ra)
    );

    obbt_rot #(.IW(RW), .QW(QW)) u_rot_rel (
        .clk (clk),
        .en  (adv),
        .q   (rq_reg),
        .m   (rm)
    );

    always_comb
    begin
        rq_sum[0] = (2*QW+2)'(pq_reg[3][0]) - (2*QW+2)'(pq_reg[0][3])
                  - (2*QW+2)'(pq_reg[1][2]) + (2*QW+2)'(pq_reg[2][1]);
        rq_sum[1] = (2*QW+2)'(pq_reg[3][1]) - (2*QW+2)'(pq_reg[1][3])
                  - (2*QW+2)'(pq_reg[2][0]) + (2*QW+2)'(pq_reg[0][2]);
        rq_sum[2] = (2*QW+2)'(pq_reg[3][2]) - (2*QW+2)'(pq_reg[2][3])
                  - (2*QW+2)'(pq_reg[0][1]) + (2*QW+2)'(pq_reg[1][0]);
        rq_sum[3] = (2*QW+2)'(pq_reg[3][3]) + (2*QW+2)'(pq_reg[0][0])
                  + (2*QW+2)'(pq_reg[1][1]) + (2*QW+2)'(pq_reg[2][2]);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                em[i][j] = (rm[i][j] < 0) ? -rm[i][j] : rm[i][j];
            end
        end
    end

    always_comb
    begin
        int i1;
        int i2;
        int j1;
        int j2;
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = SW'(t5_reg[i]);
            r_next[i] = SW'(a5_reg[i]);
            for (int j = 0; j < 3; j++)
            begin
                r_next[i] = r_next[i] + SW'(pb_reg[j][i][j] >>> F);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            p_next[3+j] = '0;
            r_next[3+j] = SW'(b5_reg[j]);
            for (int i = 0; i < 3; i++)
            begin
                p_next[3+j] = p_next[3+j] + SW'(pt_reg[i][i][j] >>> F);
                r_next[3+j] = r_next[3+j] + SW'(pa_reg[i][i][j] >>> F);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                p_next[6+3*i+j] = SW'(pt_reg[i2][i1][j] >>> F)
                                - SW'(pt_reg[i1][i2][j] >>> F);
                r_next[6+3*i+j] = SW'(pa_reg[i1][i2][j] >>> F)
                                + SW'(pa_reg[i2][i1][j] >>> F)
                                + SW'(pb_reg[j1][i][j2] >>> F)
                                + SW'(pb_reg[j2][i][j1] >>> F);
            end
        end
    end

    always_comb
    begin
        sep = 1'b0;
        for (int k = 0; k < 15; k++)
        begin
            if (((p6_reg[k] < 0) ? -p6_reg[k] : p6_reg[k]) > r6_reg[k])
            begin
                sep = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 4; m++)
            begin
                for (int n = 0; n < 4; n++)
                begin
                    pq_reg[m][n] <= (2*QW)'(qa0[m] * qb0[n]);
                end
                rq_reg[m] <= RW'(rq_sum[m] >>> F);
            end
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k] <= d0[k];
                d2_reg[k] <= d1_reg[k];
                a1_reg[k] <= a0[k];
                a2_reg[k] <= a1_reg[k];
                a3_reg[k] <= a2_reg[k];
                a4_reg[k] <= a3_reg[k];
                a5_reg[k] <= a4_reg[k];
                b1_reg[k] <= b0[k];
                b2_reg[k] <= b1_reg[k];
                b3_reg[k] <= b2_reg[k];
                b4_reg[k] <= b3_reg[k];
                b5_reg[k] <= b4_reg[k];
                t4_reg[k] <= TW'(pd_reg[0][k] >>> F) + TW'(pd_reg[1][k] >>> F)
                           + TW'(pd_reg[2][k] >>> F);
                t5_reg[k] <= t4_reg[k];
                for (int m = 0; m < 3; m++)
                begin
                    pd_reg[k][m] <= (DW+QW)'(d2_reg[k] * ra[k][m]);
                    for (int j = 0; j < 3; j++)
                    begin
                        pt_reg[k][m][j] <= (TW+QW)'(t4_reg[k] * rm[m][j]);
                        pa_reg[k][m][j] <= (CW+QW)'(a4_reg[k] * em[m][j]);
                        pb_reg[k][m][j] <= (CW+QW)'(b4_reg[k] * em[m][j]);
                    end
                end
            end
            p6_reg      <= p_next;
            r6_reg      <= r_next;
            overlap_reg <= !sep;
        end
    end

endmodule

// ===== hw/rtl/oriented_box_overlap_test.sv =====
// ============================================================================
// oriented_box_overlap_test: oriented box overlap test over 15 axes
// Keeps one reference box and tests incoming boxes against it.
// ============================================================================
// Input beats arrive on the s_axis channel. tuser carries the command: a load
// beat stores its box as the reference and produces no output beat; a test
// beat produces one output beat on m_axis whose tdata bit 0 is the overlap
// flag. Results leave in the order the test beats arrived.
// A test beat sees the reference stored by the last load beat before it.
// The block takes one beat per cycle while the queue has space. A test beat
// is written into the queue on acceptance and leaves it into the first of
// the seven multiply, sum and compare stages; the last is the output register.
// After reset the reference is a point at the origin with identity
// orientation, and the queue and pipeline are empty.
// When the receiver holds m_axis_tready low while a result is waiting, the
// whole back pipeline holds; the four-entry queue keeps accepting until it
// fills, and then s_axis_tready drops.
// ============================================================================
module oriented_box_overlap_test #(
    parameter int COORD_WIDTH = 32,
    parameter int QUAT_WIDTH  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, center_z, extent_x, extent_y, extent_z,
    // quat_x, quat_y, quat_z, quat_w, zero fill
    input  logic [((6*COORD_WIDTH-3+4*QUAT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // overlap, zero fill
    output logic [7:0] m_axis_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = QUAT_WIDTH;
    localparam int EW = 3 * (CW + 1) + 6 * (CW - 1) + 8 * QW;
    localparam int OFS_E = 3 * CW;
    localparam int OFS_Q = OFS_E + 3 * (CW - 1);

    logic signed [CW-1:0] center [3];
    logic        [CW-2:0] extent [3];
    logic signed [QW-1:0] quat   [4];
    logic                 q_valid;
    logic                 q_ready;
    logic [EW-1:0]        q_data;
    logic                 overlap;
    obbt_pkg::queue_status_t status;
    obbt_pkg::cmd_t          cmd;

    assign cmd = obbt_pkg::cmd_t'(s_axis_tuser);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            center[k] = s_axis_tdata[k*CW +: CW];
            extent[k] = s_axis_tdata[OFS_E + k*(CW-1) +: CW - 1];
        end
        for (int k = 0; k < 4; k++)
        begin
            quat[k] = s_axis_tdata[OFS_Q + k*QW +: QW];
        end
    end

    obbt_front #(.CW(CW), .QW(QW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .center   (center),
        .extent   (extent),
        .quat     (quat),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .status   (status)
    );

    obbt_back #(.CW(CW), .QW(QW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .overlap   (overlap)
    );

    assign m_axis_tdata = {7'b0, overlap};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) s_axis_tready == !status.full)
        else $error("Input ready does not follow queue space.");

    assert property (@(posedge clk) disable iff (!rst_n) !(status.full && status.empty))
        else $error("Queue is full and empty at once.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.empty && !(s_axis_tvalid && s_axis_tready)) |=> status.empty)
        else $error("Queue filled without an accepted beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.empty && s_axis_tvalid && s_axis_tready
         && (cmd == obbt_pkg::CMD_LOAD)) |=> status.empty)
        else $error("Load beat entered the queue.");
`endif

endmodule
